// ===== design/i2c_master_transaction_engine_defines.svh =====
// Assertion macros shared by the I2C master transaction engine RTL.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Invariant that must hold at every clock edge outside reset.
`define I2CM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("i2cm invariant violated");
// Same-cycle implication.
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2cm implication violated");
// Next-cycle implication.
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2cm next-cycle implication violated");
`else
`define I2CM_ASSERT(lbl, clk, rst_n, prop)
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/i2cm_pkg.sv =====
// Types, constants and the command sequence table of the I2C master engine.
`default_nettype none
package i2cm_pkg;

	localparam int WAIT_BITS_DEFAULT = 16;
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

	// Depth of the queue between the front and the bus sequencer.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Highest command code that starts a transaction.
	localparam logic [2:0] CMD_LAST = 3'd5;
	localparam int NUM_CMDS = 6;
	localparam int NUM_STEPS = 8;

	typedef enum logic [3:0] {
		OP_START  = 4'd0,
		OP_WADDRW = 4'd1,
		OP_WADDRR = 4'd2,
		OP_WREG   = 4'd3,
		OP_WDHI   = 4'd4,
		OP_WDLO   = 4'd5,
		OP_RACK   = 4'd6,
		OP_RNAK   = 4'd7,
		OP_STOP   = 4'd8
	} op_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_START0 = 5'd1,
		PH_START1 = 5'd2,
		PH_START2 = 5'd3,
		PH_START3 = 5'd4,
		PH_WBIT0  = 5'd5,
		PH_WBIT1  = 5'd6,
		PH_WBIT2  = 5'd7,
		PH_WACK0  = 5'd8,
		PH_WACK1  = 5'd9,
		PH_WACK2  = 5'd10,
		PH_RBIT0  = 5'd11,
		PH_RBIT1  = 5'd12,
		PH_RBIT2  = 5'd13,
		PH_RACK0  = 5'd14,
		PH_RACK1  = 5'd15,
		PH_RACK2  = 5'd16,
		PH_STOP0  = 5'd17,
		PH_STOP1  = 5'd18,
		PH_STOP2  = 5'd19,
		PH_FIN    = 5'd20
	} phase_t;

	// One queued tick: the decoded request plus the sampled SDA level.
	typedef struct packed {
		logic        start;
		logic [2:0]  cmd;
		logic [6:0]  addr;
		logic [7:0]  regidx;
		logic [15:0] wdata;
		logic        sda;
	} item_t;

	localparam op_t SEQ_TABLE [NUM_CMDS][NUM_STEPS] = '{
		'{OP_START, OP_WADDRW, OP_WDLO, OP_STOP, OP_STOP, OP_STOP, OP_STOP, OP_STOP},
		'{OP_START, OP_WADDRR, OP_RNAK, OP_STOP, OP_STOP, OP_STOP, OP_STOP, OP_STOP},
		'{OP_START, OP_WADDRW, OP_WREG, OP_WDLO, OP_STOP, OP_STOP, OP_STOP, OP_STOP},
		'{OP_START, OP_WADDRW, OP_WREG, OP_START, OP_WADDRR, OP_RNAK, OP_STOP, OP_STOP},
		'{OP_START, OP_WADDRW, OP_WREG, OP_START, OP_WADDRR, OP_RACK, OP_RNAK, OP_STOP},
		'{OP_START, OP_WADDRW, OP_WREG, OP_WDHI, OP_WDLO, OP_STOP, OP_STOP, OP_STOP}
	};

	// Bus operation for a given command at a given step of its sequence.
	function automatic op_t seq_op(input logic [2:0] cmd, input logic [2:0] step);
		op_t op;
		if (cmd > CMD_LAST) begin
			op = OP_STOP;
		end else begin
			op = SEQ_TABLE[cmd][step];
		end
		return op;
	endfunction

endpackage
`default_nettype wire

// ===== design/i2cm_front.sv =====
// Input side: decodes each tick's request and queues it for the bus sequencer.
`default_nettype none
`include "i2c_master_transaction_engine_defines.svh"
module i2cm_front import i2cm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command_valid,
	input  wire logic [2:0]  command,
	input  wire logic [6:0]  device_address,
	input  wire logic [7:0]  register_index,
	input  wire logic [15:0] write_data,
	input  wire logic        sda_in,
	output item_t            item,
	output logic             item_valid,
	input  wire logic        pop
);

	item_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	item_t                  wr_item;
	logic                   push;

	// Codes 6 and 7 are queued with start cleared here; they never start a transaction.
	always_comb begin
		wr_item.start  = command_valid && (command <= CMD_LAST);
		wr_item.cmd    = command;
		wr_item.addr   = device_address;
		wr_item.regidx = register_index;
		wr_item.wdata  = write_data;
		wr_item.sda    = sda_in;
	end

	assign in_ready   = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`I2CM_ASSERT(a_count_range, clk, arst_n, count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
	`I2CM_ASSERT_IMP(a_pop_not_empty, clk, arst_n, pop, count_q != '0)

endmodule
`default_nettype wire

// ===== design/i2cm_engine.sv =====
// Bus sequencer: steps the I2C state machine once per queued tick and registers the result.
`default_nettype none
`include "i2c_master_transaction_engine_defines.svh"
module i2cm_engine import i2cm_pkg::*; #(
	parameter int WAIT_COUNTER_BITS = WAIT_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire item_t       item,
	input  wire logic        item_valid,
	output logic             pop,
	input  wire logic [15:0] half_period,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             scl_low,
	output logic             sda_low,
	output logic             busy_res,
	output logic             done_res,
	output logic             acked,
	output logic [15:0]      read_data
);

	phase_t                       phase_q, n_phase;
	logic [3:0]                   bit_q, n_bit;
	logic [2:0]                   step_q, n_step;
	logic [7:0]                   shift_q, n_shift;
	logic [WAIT_COUNTER_BITS-1:0] wait_q, n_wait;
	logic [2:0]                   cmd_q, n_cmd;
	logic [6:0]                   addr_q, n_addr;
	logic [7:0]                   reg_q, n_reg;
	logic [15:0]                  wdata_q, n_wdata;
	logic [15:0]                  acc_q, n_acc;
	logic                         scl_q, n_scl;
	logic                         sda_q, n_sda;
	logic                         nak_q, n_nak;
	logic                         n_done;
	logic                         tick;
	logic                         do_begin;
	logic [2:0]                   beg_cmd;
	logic [2:0]                   beg_step;
	op_t                          beg_op;
	op_t                          cur_op;

	logic                         out_valid_q;
	logic                         scl_out_q, sda_out_q, busy_q, done_q, acked_q;
	logic [15:0]                  rdata_q;

	assign pop    = item_valid && (!out_valid_q || out_ready);
	assign cur_op = seq_op(cmd_q, step_q);

	always_comb begin
		n_phase  = phase_q;
		n_bit    = bit_q;
		n_step   = step_q;
		n_shift  = shift_q;
		n_wait   = wait_q;
		n_cmd    = cmd_q;
		n_addr   = addr_q;
		n_reg    = reg_q;
		n_wdata  = wdata_q;
		n_acc    = acc_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		n_nak    = nak_q;
		n_done   = 1'b0;
		tick     = 1'b0;
		do_begin = 1'b0;
		beg_cmd  = cmd_q;
		beg_step = step_q + 3'd1;
		beg_op   = OP_STOP;

		if (phase_q == PH_IDLE) begin
			if (item.start) begin
				n_cmd    = item.cmd;
				n_addr   = item.addr;
				n_reg    = item.regidx;
				n_wdata  = item.wdata;
				n_acc    = '0;
				n_nak    = 1'b0;
				n_wait   = '0;
				do_begin = 1'b1;
				beg_cmd  = item.cmd;
				beg_step = '0;
			end
		end else if (wait_q != '0) begin
			n_wait = wait_q - 1'b1;
		end else begin
			tick = 1'b1;
			unique case (phase_q)
				PH_START0: begin n_sda = 1'b0; n_phase = PH_START1; end
				PH_START1: begin n_scl = 1'b0; n_phase = PH_START2; end
				PH_START2: begin n_sda = 1'b1; n_phase = PH_START3; end
				PH_START3: begin n_scl = 1'b1; do_begin = 1'b1; end
				PH_WBIT0:  begin n_sda = ~shift_q[7]; n_phase = PH_WBIT1; end
				PH_WBIT1:  begin n_scl = 1'b0; n_phase = PH_WBIT2; end
				PH_WBIT2: begin
					n_scl   = 1'b1;
					n_shift = {shift_q[6:0], 1'b0};
					n_bit   = bit_q + 4'd1;
					n_phase = n_bit[3] ? PH_WACK0 : PH_WBIT0;
				end
				PH_WACK0:  begin n_sda = 1'b0; n_phase = PH_WACK1; end
				PH_WACK1:  begin n_scl = 1'b0; n_phase = PH_WACK2; end
				PH_WACK2: begin
					n_scl = 1'b1;
					if (item.sda) begin
						n_nak   = 1'b1;
						n_phase = PH_STOP0;
					end else begin
						do_begin = 1'b1;
					end
				end
				PH_RBIT0:  begin n_sda = 1'b0; n_phase = PH_RBIT1; end
				PH_RBIT1:  begin n_scl = 1'b0; n_phase = PH_RBIT2; end
				PH_RBIT2: begin
					n_scl   = 1'b1;
					n_shift = {shift_q[6:0], item.sda};
					n_bit   = bit_q + 4'd1;
					n_phase = n_bit[3] ? PH_RACK0 : PH_RBIT0;
				end
				PH_RACK0:  begin n_sda = (cur_op == OP_RACK); n_phase = PH_RACK1; end
				PH_RACK1:  begin n_scl = 1'b0; n_phase = PH_RACK2; end
				PH_RACK2: begin
					n_scl    = 1'b1;
					n_acc    = {acc_q[7:0], shift_q};
					do_begin = 1'b1;
				end
				PH_STOP0:  begin n_sda = 1'b1; n_phase = PH_STOP1; end
				PH_STOP1:  begin n_scl = 1'b0; n_phase = PH_STOP2; end
				PH_STOP2:  begin n_sda = 1'b0; n_phase = PH_FIN; end
				default: begin
					n_done  = 1'b1;
					n_phase = PH_IDLE;
				end
			endcase
		end

		// Start of the next bus operation of the sequence.
		if (do_begin) begin
			n_step = beg_step;
			n_bit  = '0;
			beg_op = seq_op(beg_cmd, beg_step);
			unique case (beg_op)
				OP_START:  n_phase = PH_START0;
				OP_WADDRW: begin n_shift = {n_addr, 1'b0}; n_phase = PH_WBIT0; end
				OP_WADDRR: begin n_shift = {n_addr, 1'b1}; n_phase = PH_WBIT0; end
				OP_WREG:   begin n_shift = n_reg; n_phase = PH_WBIT0; end
				OP_WDHI:   begin n_shift = n_wdata[15:8]; n_phase = PH_WBIT0; end
				OP_WDLO:   begin n_shift = n_wdata[7:0]; n_phase = PH_WBIT0; end
				OP_RACK, OP_RNAK: begin n_shift = '0; n_phase = PH_RBIT0; end
				default:   n_phase = PH_STOP0;
			endcase
		end

		if (tick && (n_phase != PH_IDLE)) begin
			n_wait = WAIT_COUNTER_BITS'(half_period);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			step_q  <= '0;
			shift_q <= '0;
			wait_q  <= '0;
			cmd_q   <= '0;
			addr_q  <= '0;
			reg_q   <= '0;
			wdata_q <= '0;
			acc_q   <= '0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			nak_q   <= 1'b0;
		end else if (pop) begin
			phase_q <= n_phase;
			bit_q   <= n_bit;
			step_q  <= n_step;
			shift_q <= n_shift;
			wait_q  <= n_wait;
			cmd_q   <= n_cmd;
			addr_q  <= n_addr;
			reg_q   <= n_reg;
			wdata_q <= n_wdata;
			acc_q   <= n_acc;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			nak_q   <= n_nak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			scl_out_q <= n_scl;
			sda_out_q <= n_sda;
			busy_q    <= (n_phase != PH_IDLE);
			done_q    <= n_done;
			acked_q   <= n_done && !n_nak;
			rdata_q   <= (n_done && !n_nak) ? n_acc : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_low   = scl_out_q;
	assign sda_low   = sda_out_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign acked     = acked_q;
	assign read_data = rdata_q;

	`I2CM_ASSERT_IMP(a_done_not_busy, clk, arst_n, out_valid_q && done_q, !busy_q)
	`I2CM_ASSERT_IMP(a_acked_with_done, clk, arst_n, out_valid_q && acked_q, done_q)
	`I2CM_ASSERT(a_bit_count_range, clk, arst_n, bit_q <= 4'd8)
	`I2CM_ASSERT_NXT(a_wait_countdown, clk, arst_n, pop && (phase_q != PH_IDLE) && (wait_q != '0), wait_q == $past(wait_q) - 1'b1)

endmodule
`default_nettype wire

// ===== design/i2c_master_transaction_engine.sv =====
// Top level of the I2C master transaction engine: configuration register, front queue, sequencer.
//
// Open-drain I2C master stepped by one input beat per clock tick. Every accepted input beat is
// one bus tick: it may carry a command (write byte, read byte, write register byte, read
// register byte, read register 16-bit, write register 16-bit) together with the SDA level
// sampled on that tick, and it produces exactly one output beat with the SCL and SDA drive
// state after the tick, busy, a one-tick done pulse, the acknowledge status and the read data.
// Commands that arrive while a transaction runs, and command codes 6 and 7, are ignored. Each
// line change is followed by half_period_ticks wait ticks; there is no clock stretching, and a
// NAK on any written byte ends the transaction with a stop, acked low and read data zero.
// The block takes one beat per clock cycle with both sides streaming. An accepted beat is
// written into a two-entry input queue and, unless the output is stalled, popped by the
// sequencer in the next cycle, which registers its result; the queue entry and the result
// register lie between an input beat and its result beat. A stalled output holds the
// sequencer, and the input side stops accepting once the two queue entries are full.
// The half-period register (reset 250) is written through its own channel, which is always
// ready; write it only while no transaction is in flight.
`default_nettype none
module i2c_master_transaction_engine import i2cm_pkg::*; #(
	parameter int WAIT_COUNTER_BITS = WAIT_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command_valid,
	input  wire logic [2:0]  command,
	input  wire logic [6:0]  device_address,
	input  wire logic [7:0]  register_index,
	input  wire logic [15:0] write_data,
	input  wire logic        sda_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             scl_low,
	output logic             sda_low,
	output logic             busy_res,
	output logic             done_res,
	output logic             acked,
	output logic [15:0]      read_data
);

	logic [15:0] half_period_q;
	item_t       item;
	logic        item_valid;
	logic        pop;

	// The register takes a write on every beat of the configuration channel.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			half_period_q <= cfg_data;
		end
	end

	i2cm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command_valid  (command_valid),
		.command        (command),
		.device_address (device_address),
		.register_index (register_index),
		.write_data     (write_data),
		.sda_in         (sda_in),
		.item           (item),
		.item_valid     (item_valid),
		.pop            (pop)
	);

	i2cm_engine #(
		.WAIT_COUNTER_BITS (WAIT_COUNTER_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.pop         (pop),
		.half_period (half_period_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scl_low     (scl_low),
		.sda_low     (sda_low),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.acked       (acked),
		.read_data   (read_data)
	);

endmodule
`default_nettype wire

// ===== test/i2c_master_transaction_engine_test.sv =====
// Self-checking testbench for the I2C master transaction engine, driven one bus tick per beat.
`timescale 1ns / 1ps
module i2c_master_transaction_engine_test;
	import i2cm_pkg::*;

	// Command codes carried on the command field of an input beat.
	localparam logic [2:0] CMD_WR_BYTE  = 3'd0;
	localparam logic [2:0] CMD_RD_BYTE  = 3'd1;
	localparam logic [2:0] CMD_WR_REG   = 3'd2;
	localparam logic [2:0] CMD_RD_REG   = 3'd3;
	localparam logic [2:0] CMD_RD_REG16 = 3'd4;
	localparam logic [2:0] CMD_WR_REG16 = 3'd5;
	localparam logic [2:0] CMD_BAD_LO   = 3'd6;
	localparam logic [2:0] CMD_BAD_HI   = 3'd7;

	localparam int GAP_MAX        = 18;
	localparam int REPORT_LIMIT   = 10;
	localparam int DRAIN_CYCLES   = 8;
	localparam int NO_NAK         = -1;

	// One input beat: the request fields plus the SDA level seen on that tick.
	typedef struct packed {
		logic        command_valid;
		logic [2:0]  command;
		logic [6:0]  device_address;
		logic [7:0]  register_index;
		logic [15:0] write_data;
		logic        sda_in;
	} bus_tick_t;

	// One result beat: line drive and status after the tick.
	typedef struct packed {
		logic        scl_low;
		logic        sda_low;
		logic        busy;
		logic        done;
		logic        acked;
		logic [15:0] read_data;
	} bus_view_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        command_valid;
	logic [2:0]  command;
	logic [6:0]  device_address;
	logic [7:0]  register_index;
	logic [15:0] write_data;
	logic        sda_in;
	logic        out_valid;
	logic        out_ready;
	logic        scl_low;
	logic        sda_low;
	logic        busy_res;
	logic        done_res;
	logic        acked;
	logic [15:0] read_data;

	i2c_master_transaction_engine u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command_valid  (command_valid),
		.command        (command),
		.device_address (device_address),
		.register_index (register_index),
		.write_data     (write_data),
		.sda_in         (sda_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.scl_low        (scl_low),
		.sda_low        (sda_low),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.acked          (acked),
		.read_data      (read_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the engine. It is advanced once per accepted input beat by the monitor
	// below, so it always describes the bus state after the last accepted tick.
	phase_t      bus_phase;
	logic [3:0]  bit_index;
	logic [2:0]  seq_step;
	logic [7:0]  shift_byte;
	logic [15:0] wait_left;
	logic [2:0]  txn_cmd;
	logic [6:0]  txn_addr;
	logic [7:0]  txn_reg;
	logic [15:0] txn_wdata;
	logic [15:0] read_word;
	logic        scl_pull;
	logic        sda_pull;
	logic        nak_hit;
	logic [15:0] half_period;

	// Results predicted but not yet seen on the output channel, oldest first.
	bus_view_t view_q [$];
	int        ticks_sent = 0;
	int        ticks_modeled = 0;
	int        beats_seen = 0;
	int        mismatch_count = 0;

	// Emulated target: which acknowledge slot it refuses and the bits it returns on reads.
	int          ack_slot;
	int          nak_slot;
	logic [15:0] slave_word;

	// Random pacing on both channels is switched off for the closing stretch of the run.
	logic gaps_on;

	function automatic void model_reset();
		bus_phase   = PH_IDLE;
		bit_index   = '0;
		seq_step    = '0;
		shift_byte  = '0;
		wait_left   = '0;
		txn_cmd     = '0;
		txn_addr    = '0;
		txn_reg     = '0;
		txn_wdata   = '0;
		read_word   = '0;
		scl_pull    = 1'b0;
		sda_pull    = 1'b0;
		nak_hit     = 1'b0;
		half_period = 16'd250;
	endfunction

	// Bus operation that a command performs at a given step of its sequence.
	// Every sequence pads its tail with stops.
	function automatic op_t plan_op(input logic [2:0] cmd, input logic [2:0] step_no);
		op_t op;
		op = OP_STOP;
		if (step_no == 3'd0) begin
			op = OP_START;
		end else if (step_no == 3'd1) begin
			op = (cmd == CMD_RD_BYTE) ? OP_WADDRR : OP_WADDRW;
		end else begin
			case (cmd)
			CMD_WR_BYTE: begin
				if (step_no == 3'd2) op = OP_WDLO;
			end
			CMD_RD_BYTE: begin
				if (step_no == 3'd2) op = OP_RNAK;
			end
			CMD_WR_REG: begin
				if (step_no == 3'd2) op = OP_WREG;
				else if (step_no == 3'd3) op = OP_WDLO;
			end
			CMD_RD_REG: begin
				case (step_no)
				3'd2: op = OP_WREG;
				3'd3: op = OP_START;
				3'd4: op = OP_WADDRR;
				3'd5: op = OP_RNAK;
				default: ;
				endcase
			end
			CMD_RD_REG16: begin
				case (step_no)
				3'd2: op = OP_WREG;
				3'd3: op = OP_START;
				3'd4: op = OP_WADDRR;
				3'd5: op = OP_RACK;
				3'd6: op = OP_RNAK;
				default: ;
				endcase
			end
			CMD_WR_REG16: begin
				case (step_no)
				3'd2: op = OP_WREG;
				3'd3: op = OP_WDHI;
				3'd4: op = OP_WDLO;
				default: ;
				endcase
			end
			default: ;
			endcase
		end
		return op;
	endfunction

	// Enter the first phase of the operation at the current step and preload its byte.
	function automatic void load_op();
		bit_index = '0;
		case (plan_op(txn_cmd, seq_step))
		OP_START: bus_phase = PH_START0;
		OP_WADDRW: begin
			shift_byte = {txn_addr, 1'b0};
			bus_phase  = PH_WBIT0;
		end
		OP_WADDRR: begin
			shift_byte = {txn_addr, 1'b1};
			bus_phase  = PH_WBIT0;
		end
		OP_WREG: begin
			shift_byte = txn_reg;
			bus_phase  = PH_WBIT0;
		end
		OP_WDHI: begin
			shift_byte = txn_wdata[15:8];
			bus_phase  = PH_WBIT0;
		end
		OP_WDLO: begin
			shift_byte = txn_wdata[7:0];
			bus_phase  = PH_WBIT0;
		end
		OP_RACK, OP_RNAK: begin
			shift_byte = '0;
			bus_phase  = PH_RBIT0;
		end
		default: bus_phase = PH_STOP0;
		endcase
	endfunction

	function automatic void advance_op();
		seq_step = seq_step + 3'd1;
		load_op();
	endfunction

	// Advance the shadow engine by one tick and return the result beat that tick produces.
	function automatic bus_view_t bus_step(input bus_tick_t t);
		bus_view_t view;
		logic      finished;
		finished = 1'b0;
		if (bus_phase == PH_IDLE) begin
			// The accepting tick only latches the request; the bus moves on the next one.
			if (t.command_valid && t.command <= CMD_WR_REG16) begin
				txn_cmd   = t.command;
				txn_addr  = t.device_address;
				txn_reg   = t.register_index;
				txn_wdata = t.write_data;
				read_word = '0;
				nak_hit   = 1'b0;
				seq_step  = '0;
				wait_left = '0;
				load_op();
			end
		end else if (wait_left != '0) begin
			wait_left = wait_left - 16'd1;
		end else begin
			case (bus_phase)
			PH_START0: begin
				sda_pull  = 1'b0;
				bus_phase = PH_START1;
			end
			PH_START1: begin
				scl_pull  = 1'b0;
				bus_phase = PH_START2;
			end
			PH_START2: begin
				sda_pull  = 1'b1;
				bus_phase = PH_START3;
			end
			PH_START3: begin
				scl_pull = 1'b1;
				advance_op();
			end
			PH_WBIT0: begin
				sda_pull  = !shift_byte[7];
				bus_phase = PH_WBIT1;
			end
			PH_WBIT1: begin
				scl_pull  = 1'b0;
				bus_phase = PH_WBIT2;
			end
			PH_WBIT2: begin
				scl_pull   = 1'b1;
				shift_byte = {shift_byte[6:0], 1'b0};
				bit_index  = bit_index + 4'd1;
				bus_phase  = (bit_index >= 4'd8) ? PH_WACK0 : PH_WBIT0;
			end
			PH_WACK0: begin
				sda_pull  = 1'b0;
				bus_phase = PH_WACK1;
			end
			PH_WACK1: begin
				scl_pull  = 1'b0;
				bus_phase = PH_WACK2;
			end
			PH_WACK2: begin
				scl_pull = 1'b1;
				// A released SDA in the acknowledge slot is a refusal: go straight to stop.
				if (t.sda_in) begin
					nak_hit   = 1'b1;
					bus_phase = PH_STOP0;
				end else begin
					advance_op();
				end
			end
			PH_RBIT0: begin
				sda_pull  = 1'b0;
				bus_phase = PH_RBIT1;
			end
			PH_RBIT1: begin
				scl_pull  = 1'b0;
				bus_phase = PH_RBIT2;
			end
			PH_RBIT2: begin
				scl_pull   = 1'b1;
				shift_byte = {shift_byte[6:0], t.sda_in};
				bit_index  = bit_index + 4'd1;
				bus_phase  = (bit_index >= 4'd8) ? PH_RACK0 : PH_RBIT0;
			end
			PH_RACK0: begin
				sda_pull  = (plan_op(txn_cmd, seq_step) == OP_RACK);
				bus_phase = PH_RACK1;
			end
			PH_RACK1: begin
				scl_pull  = 1'b0;
				bus_phase = PH_RACK2;
			end
			PH_RACK2: begin
				scl_pull  = 1'b1;
				read_word = {read_word[7:0], shift_byte};
				advance_op();
			end
			PH_STOP0: begin
				sda_pull  = 1'b1;
				bus_phase = PH_STOP1;
			end
			PH_STOP1: begin
				scl_pull  = 1'b0;
				bus_phase = PH_STOP2;
			end
			PH_STOP2: begin
				sda_pull  = 1'b0;
				bus_phase = PH_FIN;
			end
			default: begin
				finished  = 1'b1;
				bus_phase = PH_IDLE;
			end
			endcase
			if (bus_phase != PH_IDLE) wait_left = half_period;
		end
		view.scl_low   = scl_pull;
		view.sda_low   = sda_pull;
		view.busy      = (bus_phase != PH_IDLE);
		view.done      = finished;
		view.acked     = finished && !nak_hit;
		view.read_data = (finished && !nak_hit) ? read_word : 16'h0000;
		return view;
	endfunction

	// Monitor and scoreboard in one process, so a result can never be compared before the
	// prediction of its input beat is queued, whatever the latency of the engine. All values
	// are read at the edge before any nonblocking update of this step lands.
	always @(posedge clk) begin : bus_monitor
		bus_tick_t t;
		bus_view_t got;
		bus_view_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) half_period = cfg_data;
			if (in_valid && in_ready) begin
				t = {command_valid, command, device_address, register_index, write_data, sda_in};
				view_q.push_back(bus_step(t));
				ticks_modeled++;
			end
			if (out_valid && out_ready) begin
				got = {scl_low, sda_low, busy_res, done_res, acked, read_data};
				if (view_q.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("result beat %0d arrived with nothing expected", beats_seen);
					mismatch_count++;
				end else begin
					want = view_q.pop_front();
					if (got.scl_low !== want.scl_low || got.sda_low !== want.sda_low ||
							got.busy !== want.busy || got.done !== want.done ||
							got.acked !== want.acked || got.read_data !== want.read_data) begin
						if (mismatch_count < REPORT_LIMIT) begin
							$display("result beat %0d expected: scl_low %b sda_low %b busy %b done %b acked %b read_data %h",
								beats_seen, want.scl_low, want.sda_low, want.busy, want.done,
								want.acked, want.read_data);
							$display("result beat %0d actual:   scl_low %b sda_low %b busy %b done %b acked %b read_data %h",
								beats_seen, got.scl_low, got.sda_low, got.busy, got.done,
								got.acked, got.read_data);
						end
						mismatch_count++;
					end
				end
				beats_seen++;
			end
		end
	end

	// Result side pacing: random stall bursts while gaps are enabled, otherwise always ready.
	initial begin : result_pacing
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Offer one beat and hold it until accepted. The caller runs at the step where the previous
	// beat was accepted, so valid either stays high for this beat or drops for a gap burst;
	// it is never lowered and raised within one step. Returns once the shadow engine has taken
	// the beat, so the next beat can be built from the updated bus state.
	task automatic send_tick(input bus_tick_t t);
		if (gaps_on && $urandom_range(0, 15) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
		end
		in_valid <= 1'b1;
		{command_valid, command, device_address, register_index, write_data, sda_in} <= t;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
		wait (ticks_modeled == ticks_sent);
	endtask

	// Stop offering beats and wait until every predicted result has come back. Always lets a
	// clock edge pass first, so valid is never lowered and raised within one step.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (view_q.size() != 0);
	endtask

	task automatic set_half_period(input logic [15:0] ticks);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= ticks;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic bus_tick_t random_tick();
		bus_tick_t t;
		t.command_valid  = 1'b0;
		t.command        = 3'($urandom_range(0, 7));
		t.device_address = 7'($urandom_range(0, 127));
		t.register_index = 8'($urandom_range(0, 255));
		t.write_data     = 16'($urandom_range(0, 65535));
		t.sda_in         = 1'($urandom_range(0, 1));
		return t;
	endfunction

	// SDA level the target presents on the next tick. Only the sampling tick of an
	// acknowledge slot or a read bit matters to the engine; every other tick gets noise.
	function automatic logic target_sda();
		logic level;
		level = 1'($urandom_range(0, 1));
		if (wait_left == '0 && bus_phase == PH_WACK2) begin
			level = (ack_slot == nak_slot);
			ack_slot++;
		end else if (wait_left == '0 && bus_phase == PH_RBIT2) begin
			level      = slave_word[15];
			slave_word = {slave_word[14:0], 1'b0};
		end
		return level;
	endfunction

	// Ticks while the bus is idle: either no request or one of the two unused codes, so the
	// engine must stay idle.
	task automatic idle_ticks(input int count);
		bus_tick_t t;
		repeat (count) begin
			t = random_tick();
			t.command_valid = 1'($urandom_range(0, 1));
			if (t.command_valid) t.command = ($urandom_range(0, 1) != 0) ? CMD_BAD_LO : CMD_BAD_HI;
			send_tick(t);
		end
	endtask

	// One whole transaction from the request beat to the done pulse. The target refuses the
	// acknowledge slot numbered nak_at (counted from zero) and returns reply MSB first.
	// While busy, a share of the beats carries a fresh request that must be ignored.
	task automatic run_transfer(input logic [2:0] cmd, input logic [6:0] addr,
			input logic [7:0] reg_no, input logic [15:0] wdata, input logic [15:0] reply,
			input int nak_at, input int busy_req_pct);
		bus_tick_t t;
		ack_slot   = 0;
		nak_slot   = nak_at;
		slave_word = reply;
		t = random_tick();
		t.command_valid  = 1'b1;
		t.command        = cmd;
		t.device_address = addr;
		t.register_index = reg_no;
		t.write_data     = wdata;
		t.sda_in         = target_sda();
		send_tick(t);
		while (bus_phase != PH_IDLE) begin
			t = random_tick();
			t.command_valid = ($urandom_range(0, 99) < busy_req_pct);
			t.sda_in        = target_sda();
			send_tick(t);
		end
	endtask

	// Unused command codes and beats with no request leave the engine idle.
	task automatic test_unused_codes();
		bus_tick_t t;
		t = random_tick();
		t.command_valid = 1'b1;
		t.command       = CMD_BAD_LO;
		send_tick(t);
		t.command = CMD_BAD_HI;
		send_tick(t);
		t.command_valid = 1'b0;
		t.command       = CMD_WR_BYTE;
		send_tick(t);
		idle_ticks(6);
	endtask

	// A plain byte read with all-ones fields and a register byte write with all-zero fields,
	// with one line change per tick.
	task automatic test_command_set();
		set_half_period(16'd0);
		run_transfer(CMD_RD_BYTE, 7'h7F, 8'hFF, 16'hFFFF, 16'hFFFF, NO_NAK, 0);
		run_transfer(CMD_WR_REG, 7'h00, 8'h00, 16'h0000, 16'h0000, NO_NAK, 0);
	endtask

	// A refusal after the repeated start and one on the high data byte abort with a stop,
	// acked low and zero read data.
	task automatic test_nak_abort();
		run_transfer(CMD_RD_REG, 7'h6E, 8'h42, 16'h0000, 16'h9900, 2, 0);
		run_transfer(CMD_WR_REG16, 7'h3C, 8'hC3, 16'h5AA5, 16'h0000, 2, 0);
	endtask

	// The largest half period is written and the idle engine stepped, then a byte write
	// refused at its address runs with one wait tick after each line change.
	task automatic test_period_extremes();
		set_half_period(16'hFFFF);
		idle_ticks(4);
		set_half_period(16'd1);
		run_transfer(CMD_WR_BYTE, 7'h55, 8'h00, 16'h3CA5, 16'h0000, 0, 10);
	endtask

	// A request on every busy tick of a 16-bit read must not disturb it.
	task automatic test_busy_requests();
		set_half_period(16'd0);
		run_transfer(CMD_RD_REG16, 7'h48, 8'h0F, 16'h1234, 16'h8001, NO_NAK, 100);
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		command_valid  = 1'b0;
		command        = '0;
		device_address = '0;
		register_index = '0;
		write_data     = '0;
		sda_in         = 1'b0;
		gaps_on        = 1'b1;
		model_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unused_codes();
		test_command_set();
		test_nak_abort();
		test_period_extremes();
		gaps_on = 1'b0;
		test_busy_requests();

		// Let any stray result beat show up before the verdict.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && view_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog, sized many times over the slowest legal pacing of the whole run.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
